/* rtl/whp_pkg.sv */
// Shared types and constants for the wave header parser.
// No dependencies.
package whp_pkg;

	localparam int unsigned STATUS_W = 3;
	localparam int unsigned FRAMES_W = 35;

	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;
	localparam logic [15:0] PCM_TAG  = 16'd1;
	localparam logic [31:0] FMT_MIN  = 32'd16;

	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_WAVE   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_COMPRESSED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD        = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_FMT     = 3'd4;

	typedef enum logic [10:0] {
		S_HEAD    = 11'b000_0000_0001,
		S_NOTWAVE = 11'b000_0000_0010,
		S_CHUNK   = 11'b000_0000_0100,
		S_FMT     = 11'b000_0000_1000,
		S_SKIP    = 11'b000_0001_0000,
		S_PAD     = 11'b000_0010_0000,
		S_DATA    = 11'b000_0100_0000,
		S_DONE    = 11'b000_1000_0000,
		S_FINISH  = 11'b001_0000_0000,
		S_DIVIDE  = 11'b010_0000_0000,
		S_EMIT    = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic                restart;
		logic                pos_inc;
		logic                pos_clr;
		logic                tag_en;
		logic                size_en;
		logic                fmt_en;
		logic                fmt_seen_set;
		logic                div_start;
		logic                out_load;
		logic [STATUS_W-1:0] out_status;
		logic                use_size;
		logic                use_quot;
	} whp_cmd_t;

	typedef struct packed {
		logic idx_eq3;
		logic idx_eq11;
		logic idx_lt4;
		logic idx_eq7;
		logic idx_eq15;
		logic riff_next;
		logic wave_next;
		logic tag_fmt;
		logic tag_data;
		logic size_next_lt16;
		logic size_next_zero;
		logic size_eq16;
		logic size_odd;
		logic pos_hit;
		logic fmt_pcm;
		logic fmt_seen;
		logic prod_zero;
		logic div_done;
		logic out_free;
	} whp_stat_t;

endpackage

/* rtl/whp_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on whp_pkg.
module whp_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [whp_pkg::FRAMES_W-1:0] dividend,
	input  logic [31:0]                  divisor,
	output logic                         done,
	output logic [whp_pkg::FRAMES_W-1:0] quotient
);
	import whp_pkg::*;

	localparam int unsigned CNT_W = $clog2(FRAMES_W + 1);

	logic [FRAMES_W-1:0] dvd_q;
	logic [31:0]         rem_q;
	logic [31:0]         dsr_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [32:0]         trial;
	logic [32:0]         diff;

	assign trial = {rem_q, dvd_q[FRAMES_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAMES_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				dvd_q <= {dvd_q[FRAMES_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				dvd_q <= {dvd_q[FRAMES_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

/* rtl/whp_datapath.sv */
// Parser datapath: byte counter, tag and length shifters, held fmt fields,
// product, divider and output register. Depends on whp_pkg and whp_div.
module whp_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  whp_pkg::whp_cmd_t            cmd,
	output whp_pkg::whp_stat_t           stat,
	input  logic [7:0]                   byte_value,
	input  logic                         first_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [whp_pkg::STATUS_W-1:0] status,
	output logic [15:0]                  sample_bits,
	output logic [15:0]                  channel_count,
	output logic [31:0]                  sample_rate,
	output logic [31:0]                  data_bytes,
	output logic [whp_pkg::FRAMES_W-1:0] frame_count
);
	import whp_pkg::*;

	logic [31:0]         pos_q;
	logic [31:0]         tag_q;
	logic [31:0]         size_q;
	logic                fmt_seen_q;
	logic [15:0]         ftag_q;
	logic [15:0]         chans_q;
	logic [31:0]         rate_q;
	logic [15:0]         bits_q;
	logic [31:0]         prod_q;
	logic                out_valid_q;

	logic [31:0]         pos_eff;
	logic [31:0]         tag_eff;
	logic [31:0]         pos_next;
	logic [31:0]         tag_next;
	logic [31:0]         size_next;
	logic [FRAMES_W-1:0] quot;
	logic                div_done;

	assign pos_eff  = first_byte ? '0 : pos_q;
	assign tag_eff  = first_byte ? '0 : tag_q;
	assign pos_next = pos_eff + 32'd1;
	assign tag_next = {tag_eff[23:0], byte_value};

	// little-endian length, lane chosen by the low index bits
	always_comb begin
		size_next = size_q;
		case (pos_q[1:0])
			2'd0:    size_next = {24'd0, byte_value};
			2'd1:    size_next[15:8]  = byte_value;
			2'd2:    size_next[23:16] = byte_value;
			2'd3:    size_next[31:24] = byte_value;
			default: size_next = size_q;
		endcase
	end

	always_comb begin
		stat.idx_eq3        = (pos_eff == 32'd3);
		stat.idx_eq11       = (pos_eff == 32'd11);
		stat.idx_lt4        = (pos_eff < 32'd4);
		stat.idx_eq7        = (pos_eff == 32'd7);
		stat.idx_eq15       = (pos_eff == 32'd15);
		stat.riff_next      = (tag_next == TAG_RIFF);
		stat.wave_next      = (tag_next == TAG_WAVE);
		stat.tag_fmt        = (tag_q == TAG_FMT);
		stat.tag_data       = (tag_q == TAG_DATA);
		stat.size_next_lt16 = (size_next < FMT_MIN);
		stat.size_next_zero = (size_next == '0);
		stat.size_eq16      = (size_q == FMT_MIN);
		stat.size_odd       = size_q[0];
		stat.pos_hit        = (pos_next == size_q);
		stat.fmt_pcm        = (ftag_q == PCM_TAG);
		stat.fmt_seen       = fmt_seen_q;
		stat.prod_zero      = (prod_q == '0);
		stat.div_done       = div_done;
		stat.out_free       = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			tag_q      <= '0;
			size_q     <= '0;
			fmt_seen_q <= 1'b0;
			ftag_q     <= '0;
			chans_q    <= '0;
			rate_q     <= '0;
			bits_q     <= '0;
		end else begin
			if (cmd.restart) begin
				pos_q      <= '0;
				tag_q      <= '0;
				size_q     <= '0;
				fmt_seen_q <= 1'b0;
				ftag_q     <= '0;
				chans_q    <= '0;
				rate_q     <= '0;
				bits_q     <= '0;
			end
			if (cmd.pos_clr)
				pos_q <= '0;
			else if (cmd.pos_inc)
				pos_q <= pos_next;
			if (cmd.tag_en)
				tag_q <= tag_next;
			if (cmd.size_en)
				size_q <= size_next;
			if (cmd.fmt_seen_set)
				fmt_seen_q <= 1'b1;
			if (cmd.fmt_en) begin
				case (pos_q[3:0])
					4'd0:    ftag_q  <= {8'd0, byte_value};
					4'd1:    ftag_q[15:8] <= byte_value;
					4'd2:    chans_q <= {8'd0, byte_value};
					4'd3:    chans_q[15:8] <= byte_value;
					4'd4:    rate_q  <= {24'd0, byte_value};
					4'd5:    rate_q[15:8]  <= byte_value;
					4'd6:    rate_q[23:16] <= byte_value;
					4'd7:    rate_q[31:24] <= byte_value;
					4'd14:   bits_q  <= {8'd0, byte_value};
					4'd15:   bits_q[15:8] <= byte_value;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk)
		prod_q <= 32'(bits_q) * 32'(chans_q);

	whp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({size_q, 3'b000}),
		.divisor  (prod_q),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status        <= cmd.out_status;
			sample_bits   <= bits_q;
			channel_count <= chans_q;
			sample_rate   <= rate_q;
			data_bytes    <= cmd.use_size ? size_q : '0;
			frame_count   <= cmd.use_quot ? quot : '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/whp_ctrl.sv */
// Parser controller: phase state machine issuing datapath commands.
// Depends on whp_pkg.
module whp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               first_byte,
	input  logic               end_of_file,
	input  whp_pkg::whp_stat_t stat,
	output whp_pkg::whp_cmd_t  cmd
);
	import whp_pkg::*;

	phase_t              state_q, state_n, phase;
	logic [STATUS_W-1:0] code_q, code_n;
	logic                use_size_q, use_size_n;
	logic                use_quot_q, use_quot_n;
	logic                acc;

	assign in_stall = (state_q == S_FINISH) || (state_q == S_DIVIDE) || (state_q == S_EMIT);
	assign acc      = in_valid && !in_stall;
	assign phase    = first_byte ? S_HEAD : state_q;

	always_comb begin
		state_n    = state_q;
		code_n     = code_q;
		use_size_n = use_size_q;
		use_quot_n = use_quot_q;
		cmd        = '0;
		cmd.out_status = code_q;
		cmd.use_size   = use_size_q;
		cmd.use_quot   = use_quot_q;

		if (acc) begin
			cmd.restart = first_byte;
			if (first_byte)
				state_n = S_HEAD;
			if (end_of_file) begin
				if (phase != S_DONE) begin
					code_n     = ST_BAD;
					use_size_n = 1'b0;
					use_quot_n = 1'b0;
					state_n    = S_EMIT;
				end
			end else if (phase != S_DONE) begin
				cmd.pos_inc = 1'b1;
				use_size_n  = 1'b0;
				use_quot_n  = 1'b0;
				case (phase)
					S_HEAD, S_NOTWAVE: begin
						cmd.tag_en = 1'b1;
						if (stat.idx_eq3 && !stat.riff_next)
							state_n = S_NOTWAVE;
						if (stat.idx_eq11) begin
							if (phase == S_NOTWAVE || !stat.wave_next) begin
								code_n  = ST_NOT_WAVE;
								state_n = S_EMIT;
							end else begin
								cmd.pos_clr = 1'b1;
								state_n     = S_CHUNK;
							end
						end
					end
					S_CHUNK: begin
						if (stat.idx_lt4)
							cmd.tag_en = 1'b1;
						else
							cmd.size_en = 1'b1;
						if (stat.idx_eq7) begin
							cmd.pos_clr = 1'b1;
							if (stat.tag_fmt) begin
								if (stat.size_next_lt16) begin
									code_n  = ST_BAD;
									state_n = S_EMIT;
								end else
									state_n = S_FMT;
							end else if (stat.tag_data) begin
								state_n = stat.size_next_zero ? S_FINISH : S_DATA;
							end else begin
								state_n = stat.size_next_zero ? S_CHUNK : S_SKIP;
							end
						end
					end
					S_FMT: begin
						cmd.fmt_en = 1'b1;
						if (stat.idx_eq15) begin
							if (!stat.fmt_pcm) begin
								code_n  = ST_COMPRESSED;
								state_n = S_EMIT;
							end else begin
								cmd.fmt_seen_set = 1'b1;
								if (stat.size_eq16) begin
									cmd.pos_clr = 1'b1;
									state_n     = S_CHUNK;
								end else
									state_n = S_SKIP;
							end
						end
					end
					S_SKIP: begin
						if (stat.pos_hit) begin
							if (stat.size_odd)
								state_n = S_PAD;
							else begin
								cmd.pos_clr = 1'b1;
								state_n     = S_CHUNK;
							end
						end
					end
					S_PAD: begin
						cmd.pos_clr = 1'b1;
						state_n     = S_CHUNK;
					end
					S_DATA: begin
						if (stat.pos_hit)
							state_n = S_FINISH;
					end
					default: ;
				endcase
			end
		end else begin
			case (state_q)
				S_FINISH: begin
					use_size_n = 1'b1;
					if (!stat.fmt_seen) begin
						code_n  = ST_NO_FMT;
						state_n = S_EMIT;
					end else if (stat.prod_zero) begin
						code_n  = ST_BAD;
						state_n = S_EMIT;
					end else begin
						cmd.div_start = 1'b1;
						state_n       = S_DIVIDE;
					end
				end
				S_DIVIDE: begin
					if (stat.div_done) begin
						code_n     = ST_OK;
						use_quot_n = 1'b1;
						state_n    = S_EMIT;
					end
				end
				S_EMIT: begin
					if (stat.out_free) begin
						cmd.out_load = 1'b1;
						state_n      = S_DONE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_HEAD;
			code_q     <= ST_OK;
			use_size_q <= 1'b0;
			use_quot_q <= 1'b0;
		end else begin
			state_q    <= state_n;
			code_q     <= code_n;
			use_size_q <= use_size_n;
			use_quot_q <= use_quot_n;
		end
	end

endmodule

/* rtl/wave_header_parser.sv */
// RIFF WAVE header parser, top level.
// Depends on whp_pkg, whp_ctrl, whp_datapath (and whp_div below it).
//
// Input channel: one file byte per transaction (in_valid / in_stall), with
// first_byte restarting the parser and end_of_file closing the stream.
// Output channel: one report transaction per file (out_valid / out_stall):
// status, fmt fields, data chunk length and frame count.
//
// Throughput: one byte per cycle while the headers and chunk bodies are walked.
// Report path: a report passes through the emit step and then the output
// register; at the end of a data chunk a finish step comes first, and at the
// end of a good data chunk the frame count comes from a 35-step bit-serial
// divider run between the finish and emit steps.
// in_stall is raised only while a report is being formed (finish, divide and
// emit steps); bytes after a report are accepted and dropped until first_byte.
// A stalled report sits in the output register; the parser keeps taking bytes,
// but a new report waits in the emit step, with in_stall raised, until the register frees.
// Reset puts the parser at the file header with all held fields cleared, so
// a stream with no first_byte is parsed from byte 0.
module wave_header_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   byte_value,
	input  logic                         first_byte,
	input  logic                         end_of_file,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [whp_pkg::STATUS_W-1:0] status,
	output logic [15:0]                  sample_bits,
	output logic [15:0]                  channel_count,
	output logic [31:0]                  sample_rate,
	output logic [31:0]                  data_bytes,
	output logic [whp_pkg::FRAMES_W-1:0] frame_count
);
	import whp_pkg::*;

	whp_cmd_t  cmd;
	whp_stat_t stat;

	// sequencing: phase, report code, divider start
	whp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.first_byte  (first_byte),
		.end_of_file (end_of_file),
		.stat        (stat),
		.cmd         (cmd)
	);

	// counters, held fields, product, divider and report register
	whp_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.byte_value    (byte_value),
		.first_byte    (first_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.sample_bits   (sample_bits),
		.channel_count (channel_count),
		.sample_rate   (sample_rate),
		.data_bytes    (data_bytes),
		.frame_count   (frame_count)
	);

endmodule
